// File: sv/bpi_pkg.sv
package bpi_pkg;

    localparam int COORD_BITS    = 16;
    localparam int FRACTION_BITS = 15;

    localparam int SIZE_BITS   = COORD_BITS - 1;
    localparam int EDGE_BITS   = COORD_BITS + 1;
    localparam int DIFF_BITS   = EDGE_BITS + 1;
    localparam int AREA_BITS   = 2 * SIZE_BITS;
    localparam int UNION_BITS  = AREA_BITS + 1;
    localparam int RATIO_BITS  = FRACTION_BITS + 1;
    localparam int DIV_STAGES  = FRACTION_BITS + 1;

    localparam logic [RATIO_BITS-1:0] RATIO_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    // dividend and divisor handed from the geometry front end to the divider
    typedef struct packed {
        logic [UNION_BITS-1:0] num;
        logic [UNION_BITS-1:0] den;
        logic                  ovl;
    } t_div_in;

endpackage

// File: sv/bpi_box_if.sv
interface bpi_box_if import bpi_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [COORD_BITS-1:0] first_left;
    logic signed [COORD_BITS-1:0] first_top;
    logic [SIZE_BITS-1:0]         first_width;
    logic [SIZE_BITS-1:0]         first_height;
    logic signed [COORD_BITS-1:0] second_left;
    logic signed [COORD_BITS-1:0] second_top;
    logic [SIZE_BITS-1:0]         second_width;
    logic [SIZE_BITS-1:0]         second_height;

    modport source (
        output valid, first_left, first_top, first_width, first_height,
               second_left, second_top, second_width, second_height,
        input  ready
    );
    modport sink (
        input  valid, first_left, first_top, first_width, first_height,
               second_left, second_top, second_width, second_height,
        output ready
    );
endinterface

// File: sv/bpi_iou_if.sv
interface bpi_iou_if import bpi_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [RATIO_BITS-1:0] overlap_ratio;
    logic                  overlaps;

    modport source (output valid, overlap_ratio, overlaps, input ready);
    modport sink   (input valid, overlap_ratio, overlaps, output ready);
endinterface

// File: sv/bpi_geom.sv
module bpi_geom import bpi_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bpi_box_if.sink       i_box,
    output logic          o_valid,
    input  logic          i_ready,
    output t_div_in       o_div
);

    logic r_vld1, r_vld2, r_vld3, r_vld4;
    logic en1, en2, en3, en4;

    // stage 1: edges and box areas
    logic signed [COORD_BITS-1:0] r1_xl, r1_yt, n1_xl, n1_yt;
    logic signed [EDGE_BITS-1:0]  r1_xr, r1_yb, n1_xr, n1_yb;
    logic signed [EDGE_BITS-1:0]  w_r1, w_r2, w_b1, w_b2;
    logic [AREA_BITS-1:0]         r1_a1, r1_a2;

    // stage 2: overlap extents and area sum
    logic signed [DIFF_BITS-1:0]  w_dx, w_dy;
    logic [SIZE_BITS-1:0]         r2_ix, r2_iy;
    logic                         r2_ovl;
    logic [UNION_BITS-1:0]        r2_asum;

    // stage 3: intersection area
    logic [AREA_BITS-1:0]         r3_inter;
    logic                         r3_ovl;
    logic [UNION_BITS-1:0]        r3_asum;

    // stage 4: union and divider operands
    logic [UNION_BITS-1:0]        w_uni;
    t_div_in                      r4_div, n4_div;

    assign en4 = !r_vld4 || i_ready;
    assign en3 = !r_vld3 || en4;
    assign en2 = !r_vld2 || en3;
    assign en1 = !r_vld1 || en2;
    assign i_box.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else begin
            if (en1) r_vld1 <= i_box.valid;
            if (en2) r_vld2 <= r_vld1;
            if (en3) r_vld3 <= r_vld2;
            if (en4) r_vld4 <= r_vld3;
        end
    end

    always_comb begin
        w_r1  = EDGE_BITS'(i_box.first_left)  + $signed(EDGE_BITS'(i_box.first_width));
        w_r2  = EDGE_BITS'(i_box.second_left) + $signed(EDGE_BITS'(i_box.second_width));
        w_b1  = EDGE_BITS'(i_box.first_top)   + $signed(EDGE_BITS'(i_box.first_height));
        w_b2  = EDGE_BITS'(i_box.second_top)  + $signed(EDGE_BITS'(i_box.second_height));
        n1_xl = (i_box.first_left > i_box.second_left) ? i_box.first_left : i_box.second_left;
        n1_yt = (i_box.first_top > i_box.second_top) ? i_box.first_top : i_box.second_top;
        n1_xr = (w_r1 < w_r2) ? w_r1 : w_r2;
        n1_yb = (w_b1 < w_b2) ? w_b1 : w_b2;
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_xl <= n1_xl;
            r1_yt <= n1_yt;
            r1_xr <= n1_xr;
            r1_yb <= n1_yb;
            r1_a1 <= AREA_BITS'(i_box.first_width) * AREA_BITS'(i_box.first_height);
            r1_a2 <= AREA_BITS'(i_box.second_width) * AREA_BITS'(i_box.second_height);
        end
    end

    assign w_dx = DIFF_BITS'(r1_xr) - DIFF_BITS'(r1_xl);
    assign w_dy = DIFF_BITS'(r1_yb) - DIFF_BITS'(r1_yt);

    always_ff @(posedge i_clk) begin
        if (en2) begin
            // touching edges give a zero extent and still count as overlap
            r2_ovl  <= !w_dx[DIFF_BITS-1] && !w_dy[DIFF_BITS-1];
            r2_ix   <= w_dx[SIZE_BITS-1:0];
            r2_iy   <= w_dy[SIZE_BITS-1:0];
            r2_asum <= UNION_BITS'(r1_a1) + UNION_BITS'(r1_a2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_inter <= r2_ovl ? AREA_BITS'(r2_ix) * AREA_BITS'(r2_iy) : '0;
            r3_ovl   <= r2_ovl;
            r3_asum  <= r2_asum;
        end
    end

    assign w_uni = r3_asum - UNION_BITS'(r3_inter);

    always_comb begin
        n4_div.ovl = r3_ovl;
        // disjoint or empty union: divide zero by one so the quotient is zero
        if (!r3_ovl || w_uni == '0) begin
            n4_div.num = '0;
            n4_div.den = UNION_BITS'(1);
        end else begin
            n4_div.num = UNION_BITS'(r3_inter);
            n4_div.den = w_uni;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_div <= n4_div;
        end
    end

    assign o_valid = r_vld4;
    assign o_div   = r4_div;

    a_disjoint_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld4 && !r4_div.ovl |-> r4_div.num == '0)
        else $error("disjoint pair carries a nonzero dividend");

    a_num_le_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld4 |-> r4_div.num <= r4_div.den && r4_div.den != '0)
        else $error("dividend exceeds divisor or divisor is zero");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld4 && !i_ready |=> r_vld4 && $stable(r4_div))
        else $error("operands changed while the divider stalled");

endmodule

// File: sv/bpi_div.sv
module bpi_div import bpi_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  t_div_in       i_div,
    bpi_iou_if.source     o_iou
);

    logic                  r_vld [DIV_STAGES];
    logic                  en    [DIV_STAGES];
    logic [UNION_BITS-1:0] r_rem [DIV_STAGES];
    logic [UNION_BITS-1:0] r_den [DIV_STAGES];
    logic [RATIO_BITS-1:0] r_quo [DIV_STAGES];
    logic                  r_ovl [DIV_STAGES];

    // one restoring step per stage, first stage without the shift
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic                  p_vld;
        logic                  p_ovl;
        logic [UNION_BITS-1:0] p_den;
        logic [RATIO_BITS-1:0] p_quo;
        logic [UNION_BITS:0]   w_trial;
        logic                  w_take;
        logic [UNION_BITS-1:0] n_rem;
        logic [RATIO_BITS-1:0] n_quo;

        if (k == 0) begin : g_first
            assign p_vld   = i_valid;
            assign p_ovl   = i_div.ovl;
            assign p_den   = i_div.den;
            assign p_quo   = '0;
            assign w_trial = {1'b0, i_div.num};
        end else begin : g_next
            assign p_vld   = r_vld[k-1];
            assign p_ovl   = r_ovl[k-1];
            assign p_den   = r_den[k-1];
            assign p_quo   = r_quo[k-1];
            assign w_trial = {r_rem[k-1], 1'b0};
        end

        if (k == DIV_STAGES - 1) begin : g_last_en
            assign en[k] = !r_vld[k] || o_iou.ready;
        end else begin : g_mid_en
            assign en[k] = !r_vld[k] || en[k+1];
        end

        assign w_take = w_trial >= {1'b0, p_den};
        assign n_rem  = w_take ? UNION_BITS'(w_trial - {1'b0, p_den})
                               : w_trial[UNION_BITS-1:0];
        assign n_quo  = {p_quo[RATIO_BITS-2:0], w_take};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (en[k]) begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[k]) begin
                r_rem[k] <= n_rem;
                r_den[k] <= p_den;
                r_quo[k] <= n_quo;
                r_ovl[k] <= p_ovl;
            end
        end
    end

    assign o_ready             = en[0];
    assign o_iou.valid         = r_vld[DIV_STAGES-1];
    assign o_iou.overlap_ratio = r_quo[DIV_STAGES-1];
    assign o_iou.overlaps      = r_ovl[DIV_STAGES-1];

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> r_rem[0] < r_den[0])
        else $error("partial remainder not below divisor");

    a_ratio_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_iou.valid |-> o_iou.overlap_ratio <= RATIO_ONE)
        else $error("ratio above one");

    a_disjoint_ratio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_iou.valid && !o_iou.overlaps |-> o_iou.overlap_ratio == '0)
        else $error("disjoint pair with nonzero ratio");

endmodule

// File: sv/box_pair_iou.sv
// Channel   Dir  Interface    Payload
// i_box     in   bpi_box_if   first/second left, top (signed), width, height
// o_iou     out  bpi_iou_if   overlap_ratio (Q1.15), overlaps
//
// One box pair is taken per clock while i_box.ready is high. The path is four
// geometry stages (edges and areas, extents, intersection product, union) then
// a 16-stage restoring divider, one quotient bit per stage.
// Synchronous active-low reset clears the valid bit of every stage.
// A stall at o_iou holds each full stage; empty stages keep filling, so input
// is refused only once every stage holds a transfer.
module box_pair_iou import bpi_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bpi_box_if.sink    i_box,
    bpi_iou_if.source  o_iou
);

    logic    geom_valid;
    logic    div_ready;
    t_div_in geom_div;

    bpi_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_box   (i_box),
        .o_valid (geom_valid),
        .i_ready (div_ready),
        .o_div   (geom_div)
    );

    bpi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (geom_valid),
        .o_ready (div_ready),
        .i_div   (geom_div),
        .o_iou   (o_iou)
    );

endmodule
